>>> hw/rtl/sensor_packet_descrambler_macros.svh
// assertion macros for the sensor packet descrambler
`ifndef SENSOR_PACKET_DESCRAMBLER_MACROS_SVH
`define SENSOR_PACKET_DESCRAMBLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/spd_pkg.sv
// shared types and constants for the sensor packet descrambler
`timescale 1ns / 1ps

package spd_pkg;

  localparam logic [3:0] POS_FIRST    = 4'd1;
  localparam logic [3:0] POS_LAST     = 4'd8;
  localparam logic [3:0] POS_IDLE     = 4'd9;
  localparam logic [7:0] SCRAMBLE_ADD = 8'h24;
  localparam logic [6:0] TEMP_HIGH_MASK = 7'h7F;

  localparam logic [2:0] GRP_SERIAL    = 3'd4;
  localparam logic [2:0] GRP_TEMP_HIGH = 3'd5;
  localparam logic [2:0] GRP_TEMP_LOW  = 3'd6;

  typedef logic [7:0]  byte_t;
  typedef logic [14:0] temp_t;
  typedef logic [2:0]  grp_t;

  // status of one unpacked group
  typedef struct packed {
    byte_t pk;
    byte_t dk;
    logic  parity_bad;
  } spd_unpack_t;

endpackage

>>> hw/rtl/spd_if.sv
// request channels of the sensor packet descrambler
`timescale 1ns / 1ps

interface spd_in_if;
  logic           valid;
  logic           ready;
  spd_pkg::byte_t raw_byte;
  logic           start_req;

  modport source (output valid, output raw_byte, output start_req, input ready);
  modport sink   (input valid, input raw_byte, input start_req, output ready);
endinterface

interface spd_out_if;
  logic           valid;
  logic           ready;
  logic           parity_error;
  spd_pkg::byte_t serial;
  spd_pkg::temp_t temperature;
  spd_pkg::byte_t humidity;

  modport source (output valid, output parity_error, output serial,
                  output temperature, output humidity, input ready);
  modport sink   (input valid, input parity_error, input serial,
                  input temperature, input humidity, output ready);
endinterface

>>> hw/rtl/sensor_packet_descrambler.sv
// top level of the sensor packet descrambler
// a request is registered in the input stage, then processed; the result of byte 8
// is registered in the result register, which holds it until the sink takes it
// throughput: one byte per cycle, set by the single input register stage
// the input stalls only when byte 8 waits on a still-full result register
// reset: synchronous active-low rst_n empties both stages, position goes idle
`timescale 1ns / 1ps
`include "sensor_packet_descrambler_macros.svh"

module sensor_packet_descrambler (
  input  logic            clk,
  input  logic            rst_n,
  spd_in_if.sink          in_ch,
  spd_out_if.source       out_ch
);

  // input register stage
  logic           s1_valid_r;
  spd_pkg::byte_t s1_raw_r;
  logic           s1_start_r;

  // packet state
  logic [3:0]     pos_r, pos_nxt;
  spd_pkg::byte_t prev_raw_r;
  spd_pkg::byte_t prev_data_r;
  logic           parity_failed_r, parity_failed_nxt;
  spd_pkg::byte_t serial_hold_r;
  logic [6:0]     temp_high_hold_r;
  spd_pkg::byte_t temp_low_hold_r;

  // result register
  logic           out_valid_r;
  logic           out_parity_error_r;
  spd_pkg::byte_t out_serial_r;
  spd_pkg::temp_t out_temperature_r;
  spd_pkg::byte_t out_humidity_r;

  logic                 pos_active;
  logic                 s1_emits;
  logic                 out_free;
  logic                 s1_go;
  logic                 in_take;
  spd_pkg::grp_t        grp;
  spd_pkg::spd_unpack_t unp;

  // group index is position minus one, wraps 8 to 7 in three bits
  assign grp = pos_r[2:0] - 3'd1;

  spd_unpack u_unpack (
    .prev_raw  (prev_raw_r),
    .prev_data (prev_data_r),
    .raw       (s1_raw_r),
    .grp       (grp),
    .res       (unp)
  );

  // position 1..8 is inside a packet; 9 and unused codes act as idle
  always_comb begin
    pos_active = pos_r inside {[spd_pkg::POS_FIRST:spd_pkg::POS_LAST]};
  end

  // only the last byte of a packet produces a result
  assign s1_emits = !s1_start_r && (pos_r == spd_pkg::POS_LAST);
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && (!s1_emits || out_free);
  assign in_take  = in_ch.valid && in_ch.ready;

  // the input stage frees up whenever its byte moves on
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw_r   <= in_ch.raw_byte;
      s1_start_r <= in_ch.start_req;
    end
  end

  // next position and sticky parity flag
  always_comb begin
    pos_nxt           = pos_r;
    parity_failed_nxt = parity_failed_r;
    if (s1_start_r) begin
      pos_nxt           = spd_pkg::POS_FIRST;
      parity_failed_nxt = 1'b0;
    end else if (pos_active) begin
      parity_failed_nxt = parity_failed_r | unp.parity_bad;
      if (pos_r == spd_pkg::POS_LAST) begin
        pos_nxt = spd_pkg::POS_IDLE;
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r           <= spd_pkg::POS_IDLE;
      parity_failed_r <= 1'b0;
    end else if (s1_go) begin
      pos_r           <= pos_nxt;
      parity_failed_r <= parity_failed_nxt;
    end
  end

  // previous bytes feed the next group's unpack and descramble
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r  <= '0;
      prev_data_r <= '0;
    end else if (s1_go) begin
      if (s1_start_r) begin
        prev_raw_r  <= s1_raw_r;
        prev_data_r <= '0;
      end else if (pos_active) begin
        prev_raw_r  <= s1_raw_r;
        prev_data_r <= unp.pk;
      end
    end
  end

  // hold the descrambled fields until the packet completes
  always_ff @(posedge clk) begin
    if (s1_go && !s1_start_r && pos_active) begin
      case (grp)
        spd_pkg::GRP_SERIAL:    serial_hold_r    <= unp.dk;
        spd_pkg::GRP_TEMP_HIGH: temp_high_hold_r <= unp.dk[6:0] & spd_pkg::TEMP_HIGH_MASK;
        spd_pkg::GRP_TEMP_LOW:  temp_low_hold_r  <= unp.dk;
        default: ;
      endcase
    end
  end

  // result register, loaded by byte 8, drained by the sink
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_emits) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emits) begin
      out_parity_error_r <= parity_failed_nxt;
      if (parity_failed_nxt) begin
        out_serial_r      <= '0;
        out_temperature_r <= '0;
        out_humidity_r    <= '0;
      end else begin
        out_serial_r      <= serial_hold_r;
        out_temperature_r <= {temp_high_hold_r, temp_low_hold_r};
        out_humidity_r    <= unp.dk;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.parity_error = out_parity_error_r;
  assign out_ch.serial       = out_serial_r;
  assign out_ch.temperature  = out_temperature_r;
  assign out_ch.humidity     = out_humidity_r;

  // checks
  `SPD_ASSERT_NOW(a_pos_range, 1'b1, (pos_r >= spd_pkg::POS_FIRST) && (pos_r <= spd_pkg::POS_IDLE), "byte position out of range")
  `SPD_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_ch.ready, !(s1_go && s1_emits), "result overwritten before taken")
  `SPD_ASSERT_NEXT(a_error_zero, s1_go && s1_emits && parity_failed_nxt, out_valid_r && out_parity_error_r && (out_serial_r == '0) && (out_humidity_r == '0), "error result not zeroed")

endmodule

>>> hw/rtl/spd_unpack.sv
// unpacks one 9-bit group, checks its parity and descrambles it
`timescale 1ns / 1ps

module spd_unpack (
  input  spd_pkg::byte_t      prev_raw,
  input  spd_pkg::byte_t      prev_data,
  input  spd_pkg::byte_t      raw,
  input  spd_pkg::grp_t       grp,
  output spd_pkg::spd_unpack_t res
);

  logic [15:0]    pair;
  logic [15:0]    pair_shifted;
  logic [3:0]     shamt;
  logic [2:0]     par_idx;
  spd_pkg::byte_t pk;
  logic           par;

  assign pair         = {prev_raw, raw};
  assign shamt        = 4'd8 - {1'b0, grp};
  assign pair_shifted = pair >> shamt;
  assign pk           = pair_shifted[7:0];
  assign par_idx      = 3'd7 - grp;
  assign par          = raw[par_idx];

  always_comb begin
    res.pk         = pk;
    res.parity_bad = (^pk) ^ par;
    res.dk         = (prev_data + spd_pkg::SCRAMBLE_ADD) ^ pk;
  end

endmodule

>>> verif/tb_top.sv
// testbench for the sensor packet descrambler: directed and random packets, self-checking
`timescale 1ns / 1ps

module tb_top;

  // one decoded sensor reading as it leaves the block
  typedef struct packed {
    logic           parity_error;
    spd_pkg::byte_t serial;
    spd_pkg::temp_t temperature;
    spd_pkg::byte_t humidity;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n;

  spd_in_if  in_ch ();
  spd_out_if out_ch ();

  sensor_packet_descrambler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // readings still owed by the block, oldest first
  reading_t expected_readings[$];
  int       errors = 0;
  int       consumed_bytes = 0;

  // idling controls for the sender and the receiver
  bit idle_on = 1'b0;
  bit stall_on = 1'b0;
  int hold_cycles = 0;

  // descrambler state mirrored in the testbench
  logic [3:0]     cursor;
  spd_pkg::byte_t raw_prev;
  spd_pkg::byte_t pk_prev;
  logic           parity_seen_bad;
  spd_pkg::byte_t held_serial;
  logic [6:0]     held_temp_hi;
  spd_pkg::byte_t held_temp_lo;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_descrambler();
    cursor          = spd_pkg::POS_IDLE;
    raw_prev        = '0;
    pk_prev         = '0;
    parity_seen_bad = 1'b0;
    held_serial     = '0;
    held_temp_hi    = '0;
    held_temp_lo    = '0;
  endtask

  // takes one accepted request; returns 1 when the byte was not ignored
  function automatic bit descramble_byte(spd_pkg::byte_t raw, logic start);
    logic [15:0]    pair;
    spd_pkg::byte_t pk;
    spd_pkg::byte_t dk;
    logic           par;
    spd_pkg::grp_t  grp;
    reading_t       r;
    // a start always opens a new packet, dropping whatever was in progress
    if (start) begin
      raw_prev        = raw;
      pk_prev         = '0;
      parity_seen_bad = 1'b0;
      cursor          = spd_pkg::POS_FIRST;
      return 1'b1;
    end
    // idle, or an unused position code: the byte is dropped
    if (cursor < spd_pkg::POS_FIRST || cursor > spd_pkg::POS_LAST) return 1'b0;

    // byte n closes group n-1: leftover bits of the last byte, then the top of this one
    grp  = spd_pkg::grp_t'(cursor - 4'd1);
    pair = {raw_prev, raw} >> (4'd9 - cursor);
    pk   = pair[7:0];
    par  = raw[4'd8 - cursor];
    if ((^pk) != par) parity_seen_bad = 1'b1;

    // descramble against the previous data byte
    dk = spd_pkg::byte_t'(pk_prev + spd_pkg::SCRAMBLE_ADD) ^ pk;
    case (grp)
      spd_pkg::GRP_SERIAL:    held_serial  = dk;
      spd_pkg::GRP_TEMP_HIGH: held_temp_hi = dk[6:0] & spd_pkg::TEMP_HIGH_MASK;
      spd_pkg::GRP_TEMP_LOW:  held_temp_lo = dk;
      default: ;
    endcase
    raw_prev = raw;
    pk_prev  = pk;

    if (cursor < spd_pkg::POS_LAST) begin
      cursor = cursor + 4'd1;
      return 1'b1;
    end

    // last byte: the group just closed is the humidity byte
    cursor = spd_pkg::POS_IDLE;
    if (parity_seen_bad) begin
      r = '{parity_error: 1'b1, serial: '0, temperature: '0, humidity: '0};
    end else begin
      r = '{parity_error: 1'b0, serial: held_serial,
            temperature: {held_temp_hi, held_temp_lo}, humidity: dk};
    end
    expected_readings.push_back(r);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // packet building
  // ---------------------------------------------------------------------------

  // scramble eight data bytes into the 72-bit stream, even parity on each group
  function automatic logic [71:0] encode_packet(logic [7:0][7:0] readings);
    logic [71:0]    stream;
    spd_pkg::byte_t p;
    spd_pkg::byte_t p_last;
    stream = '0;
    p_last = '0;
    for (int k = 0; k < 8; k++) begin
      p      = readings[k] ^ spd_pkg::byte_t'(p_last + spd_pkg::SCRAMBLE_ADD);
      stream = {stream[62:0], p, ^p};
      p_last = p;
    end
    return stream;
  endfunction

  // random data bytes, with the field extremes showing up often
  function automatic logic [7:0][7:0] pick_readings();
    logic [7:0][7:0] readings;
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 9))
        0:       readings[k] = 8'h00;
        1:       readings[k] = 8'hFF;
        default: readings[k] = spd_pkg::byte_t'($urandom_range(0, 255));
      endcase
    end
    return readings;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: inputs move on the falling edge, handshakes are seen on the rising edge
  // ---------------------------------------------------------------------------

  task automatic push_byte(spd_pkg::byte_t raw, logic start);
    int gap;
    // random idle burst before the request, valid held low throughout
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.raw_byte  <= raw;
    in_ch.start_req <= start;
    // hold the request until the block takes it
    do @(posedge clk); while (!in_ch.ready);
    if (descramble_byte(raw, start)) consumed_bytes++;
  endtask

  task automatic lower_valid();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // first nbytes of a packet, byte 0 carrying the start flag
  task automatic send_packet(logic [71:0] stream, int nbytes);
    for (int i = 0; i < nbytes; i++) push_byte(stream[71 - 8 * i -: 8], i == 0);
  endtask

  // sender stays quiet until every owed reading has come out
  task automatic wait_for_readings();
    int waited;
    waited = 0;
    while (expected_readings.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_readings.size() != 0) begin
      $error("%0d readings never came out", expected_readings.size());
      errors++;
      expected_readings.delete();
    end
    // leave a margin after the last reading has come out
    repeat (6) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, plus a long hold when a test asks for one
  // ---------------------------------------------------------------------------

  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        // long hold counted here, so the sender keeps pushing into a full block
        out_ch.ready <= 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking: each reading against the oldest owed one
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_readings
    reading_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        $error("reading with none owed: parity_error=%0b serial=%0h temperature=%0h humidity=%0h",
               out_ch.parity_error, out_ch.serial, out_ch.temperature, out_ch.humidity);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        if (out_ch.parity_error !== want.parity_error) begin
          $error("parity_error: expected %0b, got %0b", want.parity_error, out_ch.parity_error);
          errors++;
        end
        if (out_ch.serial !== want.serial) begin
          $error("serial: expected %0h, got %0h", want.serial, out_ch.serial);
          errors++;
        end
        if (out_ch.temperature !== want.temperature) begin
          $error("temperature: expected %0h, got %0h", want.temperature, out_ch.temperature);
          errors++;
        end
        if (out_ch.humidity !== want.humidity) begin
          $error("humidity: expected %0h, got %0h", want.humidity, out_ch.humidity);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // bytes with no start while idle are dropped without a reading
  task automatic test_idle_bytes();
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    lower_valid();
    wait_for_readings();
  endtask

  // all-ones data gives the widest fields, all-zero data the smallest
  task automatic test_extremes();
    send_packet(encode_packet({8{8'hFF}}), 9);
    send_packet(encode_packet({8{8'h00}}), 9);
    lower_valid();
    wait_for_readings();
  endtask

  // start in the middle of a packet drops it; a stray byte after byte 8 is dropped too
  task automatic test_restart();
    send_packet(encode_packet(pick_readings()), 4);
    send_packet(encode_packet(pick_readings()), 9);
    push_byte(8'hA5, 1'b0);
    lower_valid();
    wait_for_readings();
  endtask

  // raw all-ones fails parity on every group: error flag, zeroed fields
  task automatic test_parity_error();
    send_packet({72{1'b1}}, 9);
    lower_valid();
    wait_for_readings();
  endtask

  // long receiver hold while packets keep coming, so byte 8 backs up the input
  task automatic test_backpressure();
    idle_on     = 1'b0;
    hold_cycles = 80;
    repeat (4) send_packet(encode_packet(pick_readings()), 9);
    lower_valid();
    wait_for_readings();
  endtask

  // sender stops until the block has drained, then goes on
  task automatic test_pause_until_empty();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    repeat (2) send_packet(encode_packet(pick_readings()), 9);
    lower_valid();
    wait_for_readings();
    repeat (2) send_packet(encode_packet(pick_readings()), 9);
    lower_valid();
    wait_for_readings();
  endtask

  // mostly good packets with random content, plus corrupted, cut-short and noisy ones
  task automatic test_random_traffic(int goal, bit allow_idle);
    int          target;
    int          kind;
    logic [71:0] stream;
    target = consumed_bytes + goal;
    while (consumed_bytes < target) begin
      // stretches with and without idling on either side
      idle_on  = allow_idle && ($urandom_range(0, 4) != 0);
      stall_on = allow_idle && ($urandom_range(0, 4) != 0);
      kind     = $urandom_range(0, 99);
      stream   = encode_packet(pick_readings());
      if (kind < 65) begin
        send_packet(stream, 9);
      end else if (kind < 78) begin
        // one or two flipped bits somewhere in the packet
        repeat ($urandom_range(1, 2)) stream ^= (72'd1 << $urandom_range(0, 71));
        send_packet(stream, 9);
      end else if (kind < 86) begin
        // cut short; the next sequence opens with a start
        send_packet(stream, $urandom_range(1, 8));
      end else if (kind < 92) begin
        // noise bytes, occasionally with a start
        repeat ($urandom_range(1, 4))
          push_byte(spd_pkg::byte_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else if (kind < 97) begin
        // trailing bytes after a full packet are dropped
        send_packet(stream, 9);
        repeat ($urandom_range(1, 3))
          push_byte(spd_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_packet(stream, 9);
        lower_valid();
        wait_for_readings();
      end
    end
    lower_valid();
    wait_for_readings();
  endtask

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.raw_byte  = '0;
    in_ch.start_req = 1'b0;
    clear_descrambler();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_idle_bytes();
    test_extremes();
    test_restart();
    test_parity_error();
    test_backpressure();
    test_pause_until_empty();
    test_random_traffic(560, 1'b1);
    // closing stretch runs at full rate on both sides
    idle_on  = 1'b0;
    stall_on = 1'b0;
    test_random_traffic(120, 1'b0);

    // late or extra readings still get caught by the checker here
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("sensor_packet_descrambler test passed");
    end else begin
      $display("sensor_packet_descrambler test failed");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("sensor_packet_descrambler test failed");
    $finish;
  end

endmodule
